@@ design/cbpw_pkg.sv @@
`default_nettype none

package cbpw_pkg;

	// fixed field widths of the channels and the register port
	localparam int CFG_W       = 32;
	localparam int COORD_W     = 32;
	localparam int RANDOM_BITS = 16;

	// register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_CELL_SCALE  = 2'd0,
		REG_LEFT_RATIO  = 2'd1,
		REG_RIGHT_RATIO = 2'd2,
		REG_WEIGHT      = 2'd3
	} cfg_reg_t;

	// one input point
	typedef struct packed {
		logic signed [COORD_W-1:0] x_in;
		logic signed [COORD_W-1:0] y_in;
		logic [RANDOM_BITS-1:0]    random_fraction;
	} point_t;

	// one warped point
	typedef struct packed {
		logic signed [COORD_W-1:0] x_out;
		logic signed [COORD_W-1:0] y_out;
	} warp_t;

endpackage

`default_nettype wire

@@ design/cell_border_point_warp.sv @@
`default_nettype none

// Cell border warp for a stream of fixed-point points. Each point (x, y, random fraction) is
// accepted while point_stall is low, and a new one may follow in every cycle unless a stall
// holds the pipeline; the warped points appear in the order the points came in. Most of the
// pipeline is the restoring divider that forms the ratio of the minor to the dominant cell
// offset: one quotient bit per pipeline stage, FRAC_BITS + 1 stages. The remaining stages
// hold the rounding split, the offset scaling multiply, the split side-term and weight
// multiplies and the final saturation. A stall on the result side while a finished point
// waits freezes the whole pipeline and is passed back to the point side in the same cycle.
// Registers must be written through the plain write port only while no point is in flight;
// the block does not enforce this, and values derived from them are registered behind them.
module cell_border_point_warp #(
	parameter int FRAC_BITS = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  cbpw_pkg::cfg_reg_t    cfg_index,
	input  wire [31:0]            cfg_data,
	input  wire                   point_valid,
	output logic                  point_stall,
	input  cbpw_pkg::point_t      point,
	output logic                  warp_valid,
	input  wire                   warp_stall,
	output cbpw_pkg::warp_t       warp
);
	import cbpw_pkg::*;

	localparam int F     = FRAC_BITS;
	localparam int CW    = CFG_W;
	localparam int XW    = COORD_W;
	localparam int RB    = RANDOM_BITS;
	localparam int IW    = XW + 1 - F;      // rounded integer part
	localparam int OW    = F + 1;           // signed offset
	localparam int PXW   = OW + CW + 1;     // offset times scale
	localparam int BW    = XW + 2;          // scaled offset plus integer
	localparam int MW    = 2 * CW;
	localparam int PW    = MW - F;          // push and threshold terms
	localparam int QW    = F + 1;           // offset ratio
	localparam int DIV_N = QW;
	localparam int LPW   = CW + QW;         // low partial product of the side term
	localparam int HPW   = PW - CW + QW;    // high partial product of the side term
	localparam int UW    = PW + QW;
	localparam int SW    = PW + 2;          // warped sum before weighting
	localparam int WHW   = SW - XW;         // high slice of the sum
	localparam int WLW   = XW + 1 + CW;     // low weight product
	localparam int FW    = SW + CW;         // full weighted product
	localparam int SHW   = FW - F;

	localparam logic [CW-1:0] CFG_HALF = CW'(1) << (F - 1);
	localparam logic [CW-1:0] CFG_ONE  = CW'(1) << F;
	localparam logic [F-1:0]  FR_HALF  = {1'b1, {(F - 1){1'b0}}};
	localparam logic [QW-1:0] QUO_MAX  = {1'b1, {F{1'b0}}};

	typedef struct packed {
		logic signed [IW-1:0] rint;
		logic signed [OW-1:0] off;
	} split_t;

	// item state through the divider stages
	typedef struct packed {
		logic signed [BW-1:0] base_x;
		logic signed [BW-1:0] base_y;
		logic                 xmaj;
		logic                 majneg;
		logic                 minneg;
		logic                 majz;
		logic                 brd;
		logic [F-1:0]         maj;
		logic [F-1:0]         rem;
		logic [QW-1:0]        quo;
	} dv_t;

	// nearest integer with ties to even, and the offset left over
	function automatic split_t split_coord(input logic [XW-1:0] v);
		logic [F-1:0] frac;
		logic         up;
		split_t       s;
		frac   = v[F-1:0];
		up     = (frac > FR_HALF) || ((frac == FR_HALF) && v[F]);
		s.rint = {v[XW-1], v[XW-1:F]} + IW'(up);
		s.off  = {up, frac};
		return s;
	endfunction

	// drop fraction bits and clamp to the coordinate range
	function automatic logic [XW-1:0] clamp_coord(input logic [FW-1:0] f);
		logic [SHW-1:0] sh;
		logic           fits;
		sh   = f[FW-1:F];
		fits = (&sh[SHW-1:XW-1]) || !(|sh[SHW-1:XW-1]);
		if (fits) begin
			return sh[XW-1:0];
		end else if (sh[SHW-1]) begin
			return {1'b1, {(XW - 1){1'b0}}};
		end else begin
			return {1'b0, {(XW - 1){1'b1}}};
		end
	endfunction

	logic adv;

	logic [CW-1:0]        cell_scale_q, left_ratio_q, right_ratio_q;
	logic signed [CW-1:0] weight_q;
	logic [CW-1:0]        cfg_nz;
	logic [MW-1:0]        lp_prod, rp_prod;
	logic [PW-1:0]        p_q, tp_q;
	logic [PW:0]          t_sum;
	logic                 t_big_q;
	logic [F-1:0]         t_low_q;

	logic v_s1, v_s2, v_s3, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic [DIV_N:0] dv_vld_s;

	logic [XW-1:0]        x_s1, y_s1;
	logic [RB-1:0]        r_s1, r_s2;
	split_t               sx_split, sy_split;
	logic signed [IW-1:0] rx_s2, ry_s2, rx_s3, ry_s3;
	logic signed [OW-1:0] ox_s2, oy_s2;
	logic signed [PXW-1:0] prodx_s3, prody_s3;
	logic [F-1:0]         mx_s3, my_s3;
	logic                 oxneg_s3, oyneg_s3, brd_s3;
	logic                 brd_now;

	dv_t dv_init;
	dv_t dv_s [DIV_N+1];
	dv_t dv_nxt [1:DIV_N];

	logic [QW-1:0]         ratio;
	logic [LPW-1:0]        pl_s5;
	logic [HPW-1:0]        ph_s5;
	logic signed [BW-1:0]  bx_s5, by_s5, bx_s6, by_s6, bx_s7, by_s7;
	logic                  xmaj_s5, majneg_s5, minneg_s5, brd_s5;
	logic                  xmaj_s6, majneg_s6, minneg_s6, brd_s6;
	logic                  xmaj_s7, brd_s7;
	logic [UW-1:0]         u_s6;
	logic [UW-F-1:0]       side_fl;
	logic                  side_rm;
	logic [SW-1:0]         side_s7, push_s7;
	logic [SW-1:0]         sx_s8, sy_s8;
	logic [SW-1:0]         term_x, term_y;
	logic signed [WLW-1:0] xlo_s9, ylo_s9;
	logic signed [SW-1:0]  xhi_s9, yhi_s9;
	logic [FW-1:0]         xf_s10, yf_s10;
	warp_t                 warp_s11;

	// pipeline moves unless a finished result waits under a stall
	assign adv         = !v_s11 || !warp_stall;
	assign point_stall = !adv;
	assign warp_valid  = v_s11;
	assign warp        = warp_s11;

	// register writes, a zero stored as the smallest unit except in the weight
	assign cfg_nz = (cfg_data == '0) ? CW'(1) : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_scale_q  <= CFG_HALF;
			left_ratio_q  <= CFG_HALF;
			right_ratio_q <= CFG_HALF;
			weight_q      <= CFG_ONE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CELL_SCALE:  cell_scale_q  <= cfg_nz;
				REG_LEFT_RATIO:  left_ratio_q  <= cfg_nz;
				REG_RIGHT_RATIO: right_ratio_q <= cfg_nz;
				REG_WEIGHT:      weight_q      <= cfg_data;
			endcase
		end
	end

	// push and threshold terms, kept current from the registers
	assign lp_prod = cell_scale_q * left_ratio_q;
	assign rp_prod = cell_scale_q * right_ratio_q;
	assign t_sum   = {1'b0, tp_q} + {{(PW + 1 - CW){1'b0}}, cell_scale_q};

	always_ff @(posedge clk) begin
		p_q     <= lp_prod[MW-1:F];
		tp_q    <= rp_prod[MW-1:F];
		t_big_q <= |t_sum[PW:F];
		t_low_q <= t_sum[F-1:0];
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			dv_vld_s <= '0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			v_s7     <= 1'b0;
			v_s8     <= 1'b0;
			v_s9     <= 1'b0;
			v_s10    <= 1'b0;
			v_s11    <= 1'b0;
		end else if (adv) begin
			v_s1     <= point_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			dv_vld_s <= {dv_vld_s[DIV_N-1:0], v_s3};
			v_s5     <= dv_vld_s[DIV_N];
			v_s6     <= v_s5;
			v_s7     <= v_s6;
			v_s8     <= v_s7;
			v_s9     <= v_s8;
			v_s10    <= v_s9;
			v_s11    <= v_s10;
		end
	end

	// rounding split and border decision
	assign sx_split = split_coord(x_s1);
	assign sy_split = split_coord(y_s1);
	assign brd_now  = t_big_q || ({r_s2, {F{1'b0}}} < {t_low_q, {RB{1'b0}}});

	// dominant axis choice and divider entry
	always_comb begin
		dv_init.base_x = $signed(prodx_s3[PXW-1:F])
			+ $signed({rx_s3[IW-1], rx_s3, {F{1'b0}}});
		dv_init.base_y = $signed(prody_s3[PXW-1:F])
			+ $signed({ry_s3[IW-1], ry_s3, {F{1'b0}}});
		dv_init.xmaj   = mx_s3 >= my_s3;
		dv_init.maj    = dv_init.xmaj ? mx_s3 : my_s3;
		dv_init.rem    = dv_init.xmaj ? my_s3 : mx_s3;
		dv_init.majneg = dv_init.xmaj ? oxneg_s3 : oyneg_s3;
		dv_init.minneg = dv_init.xmaj ? oyneg_s3 : oxneg_s3;
		dv_init.majz   = (dv_init.maj == '0);
		dv_init.brd    = brd_s3;
		dv_init.quo    = '0;
	end

	// restoring divider, one quotient bit per stage
	always_comb begin
		logic [F:0] trial;
		logic       ge;
		for (int k = 1; k <= DIV_N; k++) begin
			trial          = (k == 1) ? {1'b0, dv_s[k-1].rem} : {dv_s[k-1].rem, 1'b0};
			ge             = trial >= {1'b0, dv_s[k-1].maj};
			dv_nxt[k]      = dv_s[k-1];
			dv_nxt[k].rem  = ge ? F'(trial - {1'b0, dv_s[k-1].maj}) : trial[F-1:0];
			dv_nxt[k].quo  = {dv_s[k-1].quo[QW-2:0], ge};
		end
	end

	// side term rounding: floor when positive, negated ceiling when negative
	assign ratio   = dv_s[DIV_N].majz ? '0 : dv_s[DIV_N].quo;
	assign side_fl = u_s6[UW-1:F];
	assign side_rm = |u_s6[F-1:0];

	// the push goes on the dominant axis, the side term on the other
	assign term_x = xmaj_s7 ? push_s7 : side_s7;
	assign term_y = xmaj_s7 ? side_s7 : push_s7;

	// datapath registers
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= point.x_in;
			y_s1 <= point.y_in;
			r_s1 <= point.random_fraction;

			rx_s2 <= sx_split.rint;
			ox_s2 <= sx_split.off;
			ry_s2 <= sy_split.rint;
			oy_s2 <= sy_split.off;
			r_s2  <= r_s1;

			prodx_s3 <= $signed(ox_s2) * $signed({1'b0, cell_scale_q});
			prody_s3 <= $signed(oy_s2) * $signed({1'b0, cell_scale_q});
			mx_s3    <= ox_s2[F] ? (~ox_s2[F-1:0]) + F'(1) : ox_s2[F-1:0];
			my_s3    <= oy_s2[F] ? (~oy_s2[F-1:0]) + F'(1) : oy_s2[F-1:0];
			oxneg_s3 <= ox_s2[F];
			oyneg_s3 <= oy_s2[F];
			rx_s3    <= rx_s2;
			ry_s3    <= ry_s2;
			brd_s3   <= brd_now;

			dv_s[0] <= dv_init;
			for (int k = 1; k <= DIV_N; k++) begin
				dv_s[k] <= dv_nxt[k];
			end

			// side term partial products
			pl_s5     <= p_q[CW-1:0] * ratio;
			ph_s5     <= p_q[PW-1:CW] * ratio;
			bx_s5     <= dv_s[DIV_N].base_x;
			by_s5     <= dv_s[DIV_N].base_y;
			xmaj_s5   <= dv_s[DIV_N].xmaj;
			majneg_s5 <= dv_s[DIV_N].majneg;
			minneg_s5 <= dv_s[DIV_N].minneg;
			brd_s5    <= dv_s[DIV_N].brd;

			u_s6      <= {ph_s5, {CW{1'b0}}} + {{(UW - LPW){1'b0}}, pl_s5};
			bx_s6     <= bx_s5;
			by_s6     <= by_s5;
			xmaj_s6   <= xmaj_s5;
			majneg_s6 <= majneg_s5;
			minneg_s6 <= minneg_s5;
			brd_s6    <= brd_s5;

			side_s7 <= minneg_s6 ? (~{1'b0, side_fl}) + SW'(!side_rm) : {1'b0, side_fl};
			push_s7 <= majneg_s6 ? SW'(0) - {2'b0, p_q} : {2'b0, p_q};
			bx_s7   <= bx_s6;
			by_s7   <= by_s6;
			xmaj_s7 <= xmaj_s6;
			brd_s7  <= brd_s6;

			sx_s8 <= {{(SW - BW){bx_s7[BW-1]}}, bx_s7} + (brd_s7 ? term_x : SW'(0));
			sy_s8 <= {{(SW - BW){by_s7[BW-1]}}, by_s7} + (brd_s7 ? term_y : SW'(0));

			// weight multiply split into a low and a high slice
			xlo_s9 <= $signed({1'b0, sx_s8[XW-1:0]}) * weight_q;
			ylo_s9 <= $signed({1'b0, sy_s8[XW-1:0]}) * weight_q;
			xhi_s9 <= $signed(sx_s8[SW-1:XW]) * weight_q;
			yhi_s9 <= $signed(sy_s8[SW-1:XW]) * weight_q;

			xf_s10 <= {xhi_s9[FW-XW-1:0], {XW{1'b0}}}
				+ {{(FW - WLW){xlo_s9[WLW-1]}}, xlo_s9};
			yf_s10 <= {yhi_s9[FW-XW-1:0], {XW{1'b0}}}
				+ {{(FW - WLW){ylo_s9[WLW-1]}}, ylo_s9};

			warp_s11.x_out <= clamp_coord(xf_s10);
			warp_s11.y_out <= clamp_coord(yf_s10);
		end
	end

	// divider keeps its remainder below the divisor at every step
	for (genvar k = 1; k <= DIV_N; k++) begin : g_div_chk
		a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
			dv_vld_s[k] && !dv_s[k].majz |-> dv_s[k].rem < dv_s[k].maj)
			else $error("divider remainder not below divisor");
	end

	// minor offset never exceeds the dominant one, so the ratio stays within one
	a_ratio_max: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld_s[DIV_N] && !dv_s[DIV_N].majz |-> dv_s[DIV_N].quo <= QUO_MAX)
		else $error("offset ratio above one");

	// recombined side product fits below its top bit
	a_side_fit: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> !u_s6[UW-1])
		else $error("side term product overflow");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import cbpw_pkg::*;

	localparam int FRAC = 16;
	localparam int LATENCY = FRAC + 12;
	localparam logic [63:0] SAT_MAG = 64'd1 << 62;
	localparam longint OUT_MAX = 2147483647;
	localparam longint OUT_MIN = -OUT_MAX - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	cfg_reg_t cfg_index = REG_CELL_SCALE;
	logic [CFG_W-1:0] cfg_data = '0;
	logic point_valid = 1'b0;
	logic point_stall;
	point_t point = '0;
	logic warp_valid;
	logic warp_stall = 1'b0;
	warp_t warp;

	cell_border_point_warp #(
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point(point),
		.warp_valid(warp_valid),
		.warp_stall(warp_stall),
		.warp(warp)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// register copies, starting from their reset values
	logic [31:0] cell_scale_q = 32'h0000_8000;
	logic [31:0] left_q = 32'h0000_8000;
	logic [31:0] right_q = 32'h0000_8000;
	logic signed [31:0] weight_q = 32'sh0001_0000;

	warp_t expected_warps[$];
	int error_count = 0;
	int points_sent = 0;
	int warps_checked = 0;
	int border_hits = 0;
	int input_stalls = 0;
	bit sender_calm = 1'b0;
	bit receiver_calm = 1'b0;
	int hold_request = 0;

	// floor(a * b / 2^FRAC) with the magnitude clipped at 2^62
	function automatic longint qmul(input longint a, input logic [63:0] b);
		logic [63:0] a_mag;
		logic [127:0] prod;
		logic [127:0] whole;
		logic [63:0] mag_q;
		logic lost;
		a_mag = (a < 0) ? -a : a;
		prod = {64'd0, a_mag} * {64'd0, b};
		lost = |prod[FRAC-1:0];
		whole = prod >> FRAC;
		mag_q = (whole > {64'd0, SAT_MAG}) ? SAT_MAG : whole[63:0];
		return (a < 0) ? -(longint'(mag_q) + longint'(lost)) : longint'(mag_q);
	endfunction

	// nearest integer, ties to even, and the offset left over
	function automatic void round_split(input longint v, output longint whole,
			output longint frac_off);
		logic [63:0] bits;
		logic [FRAC-1:0] frac;
		bits = v;
		frac = bits[FRAC-1:0];
		whole = v - longint'(frac);
		if (frac > (1 << (FRAC - 1)) || (frac == (1 << (FRAC - 1)) && bits[FRAC]))
			whole += longint'(1) << FRAC;
		frac_off = v - whole;
	endfunction

	// push on the minor axis, in proportion to the minor/major offset ratio
	function automatic longint side_shift(input longint push, input longint minor,
			input longint major);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] ratio;
		if (major == 0)
			return 0;
		num = ((minor < 0) ? -minor : minor) << FRAC;
		den = (major < 0) ? -major : major;
		ratio = num / den;
		return qmul((minor < 0) ? -push : push, ratio);
	endfunction

	// weight multiply and clamp to the output range
	function automatic logic signed [31:0] weigh(input longint total);
		longint w;
		longint r;
		w = weight_q;
		r = (w < 0) ? qmul(-total, -w) : qmul(total, w);
		if (r > OUT_MAX)
			r = OUT_MAX;
		if (r < OUT_MIN)
			r = OUT_MIN;
		return 32'(r);
	endfunction

	// border threshold c + c*right under the current registers
	function automatic longint border_limit();
		return cell_scale_q + qmul(cell_scale_q, right_q);
	endfunction

	// expected warped point for one input point
	function automatic warp_t warp_of(input point_t p, output bit border);
		longint x, y, rx, ry, ox, oy, sx, sy, push, thresh, mx, my;
		warp_t w;
		x = longint'(signed'(p.x_in));
		y = longint'(signed'(p.y_in));
		push = qmul(cell_scale_q, left_q);
		thresh = border_limit();
		round_split(x, rx, ox);
		round_split(y, ry, oy);
		sx = qmul(ox, cell_scale_q) + rx;
		sy = qmul(oy, cell_scale_q) + ry;
		if (thresh >= (longint'(1) << FRAC))
			border = 1'b1;
		else
			border = (longint'(p.random_fraction) << FRAC) < (thresh << RANDOM_BITS);
		if (border) begin
			mx = (ox < 0) ? -ox : ox;
			my = (oy < 0) ? -oy : oy;
			// x wins a tie in magnitude
			if (mx >= my) begin
				sx += (ox >= 0) ? push : -push;
				sy += side_shift(push, oy, ox);
			end else begin
				sy += (oy >= 0) ? push : -push;
				sx += side_shift(push, ox, oy);
			end
		end
		w.x_out = weigh(sx);
		w.y_out = weigh(sy);
		return w;
	endfunction

	function automatic point_t pt(input logic [31:0] x, y, input logic [15:0] r);
		point_t p;
		p.x_in = x;
		p.y_in = y;
		p.random_fraction = r;
		return p;
	endfunction

	// coordinates biased toward ties, integers and tiny offsets
	function automatic logic signed [31:0] rand_coord();
		logic signed [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 5))
		1: v[15:0] = 16'h8000;
		2: v[15:0] = 16'h8000 + $urandom_range(0, 2) - 1;
		3: v[15:0] = 16'h0000;
		4: v = $urandom_range(0, 32'h000F_FFFF) - 32'h0007_FFFF;
		5: v[15:0] = $urandom_range(0, 1) ? 16'h0001 : 16'hFFFF;
		default: ;
		endcase
		return v;
	endfunction

	function automatic point_t rand_point();
		point_t p;
		longint thresh;
		p.x_in = rand_coord();
		p.y_in = rand_coord();
		// equal or mirrored offset magnitudes
		if ($urandom_range(0, 7) == 0)
			p.y_in[15:0] = $urandom_range(0, 1) ? p.x_in[15:0] : -p.x_in[15:0];
		thresh = border_limit();
		if (thresh < (longint'(1) << FRAC) && $urandom_range(0, 2) == 0)
			p.random_fraction = 16'(thresh + $urandom_range(0, 2) - 1);
		else
			p.random_fraction = $urandom;
		return p;
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= 40)
			$display("mismatch at %0t ns: %s", $time, what);
	endtask

	// offer one point, hold it until the transfer, then record its warp
	task automatic send_point(input point_t p);
		int gap;
		bit border;
		warp_t w;
		gap = sender_calm ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			point_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point_valid <= 1'b1;
		point <= p;
		@(posedge clk);
		while (point_stall !== 1'b0) begin
			input_stalls++;
			@(posedge clk);
		end
		w = warp_of(p, border);
		expected_warps.push_back(w);
		points_sent++;
		if (border)
			border_hits++;
	endtask

	// stop offering and wait for every warp still in flight
	task automatic settle();
		point_valid <= 1'b0;
		while (expected_warps.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
		REG_CELL_SCALE: cell_scale_q = (val == 0) ? 32'd1 : val;
		REG_LEFT_RATIO: left_q = (val == 0) ? 32'd1 : val;
		REG_RIGHT_RATIO: right_q = (val == 0) ? 32'd1 : val;
		REG_WEIGHT: weight_q = val;
		endcase
	endtask

	task automatic set_regs(input logic [31:0] scale, left, right, wt);
		settle();
		write_reg(REG_CELL_SCALE, scale);
		write_reg(REG_LEFT_RATIO, left);
		write_reg(REG_RIGHT_RATIO, right);
		write_reg(REG_WEIGHT, wt);
		cfg_we <= 1'b0;
		// derived values are registered behind the written registers, so let them settle
		repeat (3) @(posedge clk);
	endtask

	task automatic run_points(input int count, input int calm_count);
		for (int i = 0; i < count; i++) begin
			sender_calm = (i < calm_count);
			receiver_calm = (i < calm_count);
			send_point(rand_point());
		end
		sender_calm = 1'b0;
		receiver_calm = 1'b0;
	endtask

	// reset registers: threshold is 0.75, so the random compare matters
	task automatic test_directed_points();
		// both offsets zero: no ratio, x moves by +P
		send_point(pt(32'h0000_0000, 32'h0000_0000, 16'h0000));
		send_point(pt(32'h0003_0000, 32'hFFFB_0000, 16'h1234));
		// halves round to the even integer
		send_point(pt(32'h0000_8000, 32'h0001_8000, 16'h0000));
		send_point(pt(32'hFFFF_8000, 32'hFFFE_8000, 16'h0000));
		// equal magnitudes, x taken as dominant
		send_point(pt(32'h0000_4000, 32'h0000_4000, 16'h0000));
		send_point(pt(32'h0002_C000, 32'h0005_4000, 16'h0000));
		// y dominant with a negative minor offset
		send_point(pt(32'h0001_F000, 32'h0000_6000, 16'h0000));
		// either side of the threshold
		send_point(pt(32'h0000_3000, 32'h0000_1000, 16'd49151));
		send_point(pt(32'h0000_3000, 32'h0000_1000, 16'd49152));
		send_point(pt(32'h0000_3000, 32'h0000_1000, 16'hFFFF));
		// coordinate extremes
		send_point(pt(32'h7FFF_FFFF, 32'h8000_0000, 16'h0000));
		send_point(pt(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF));
		send_point(pt(32'hFFFF_FFFF, 32'h0000_0001, 16'h0000));
		send_point(pt(32'h7FFF_8000, 32'h8000_8000, 16'h0001));
	endtask

	task automatic test_register_extremes();
		// zero writes become the smallest unit: border only at random zero
		set_regs(32'h0, 32'h0, 32'h0, 32'h0001_0000);
		send_point(pt(32'h0001_2345, 32'hFFFF_0000, 16'h0000));
		send_point(pt(32'h0001_2345, 32'hFFFF_0000, 16'h0001));
		// full-scale registers with the largest weight
		set_regs('1, '1, '1, 32'h7FFF_FFFF);
		send_point(pt(32'h0000_0000, 32'h0000_0000, 16'hFFFF));
		send_point(pt(32'h0000_7FFF, 32'hFFFF_8001, 16'h0000));
		send_point(pt(32'h8000_0000, 32'h8000_0000, 16'h8000));
		// threshold above one, most negative weight
		set_regs(32'h0001_0000, 32'h0000_8000, 32'h1, 32'h8000_0000);
		send_point(pt(32'h0004_2000, 32'hFFFD_E000, 16'hFFFF));
		send_point(pt(32'h1234_5678, 32'h0000_0000, 16'h0000));
		// zero weight
		set_regs(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0);
		send_point(pt(32'h7FFF_FFFF, 32'h8000_0000, 16'h0000));
	endtask

	task automatic test_random_settings();
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
			0: set_regs(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0001_0000);
			1: set_regs($urandom_range(1, 32'h0002_0000), $urandom_range(1, 32'h0002_0000),
					$urandom_range(1, 32'h0001_0000),
					$urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
			2: set_regs(32'h0, 32'h0, 32'h0, 32'h0001_0000);
			3: set_regs('1, '1, '1, 32'h7FFF_FFFF);
			4: set_regs($urandom, $urandom, $urandom, 32'h8000_0000);
			5: set_regs(32'h0001_0000, $urandom_range(1, 32'h0001_0000), 32'h1, 32'hFFFF_0000);
			default: set_regs($urandom, $urandom, $urandom, $urandom);
			endcase
			run_points(240, 40);
		end
	endtask

	// long receiver hold while points keep coming, so the pipeline backs up
	task automatic test_backpressure();
		set_regs($urandom_range(1, 32'h0001_8000), $urandom_range(1, 32'h0001_0000),
				$urandom_range(1, 32'h0000_8000), 32'h0001_0000);
		hold_request = 150;
		sender_calm = 1'b1;
		for (int i = 0; i < 120; i++)
			send_point(rand_point());
		sender_calm = 1'b0;
	endtask

	// result side: random holds, then take and check one warped point
	initial begin : warp_sink
		int hold;
		@(posedge arst_n);
		forever begin
			if (hold_request > 0) begin
				hold = hold_request;
				hold_request = 0;
			end else begin
				hold = receiver_calm ? 0 : $urandom_range(0, 17);
			end
			if (hold > 0) begin
				warp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			warp_stall <= 1'b0;
			@(posedge clk);
			while (warp_valid !== 1'b1)
				@(posedge clk);
			check_warp(warp);
		end
	end

	task automatic check_warp(input warp_t got);
		warp_t want;
		if (expected_warps.size() == 0) begin
			report_mismatch($sformatf("warp x=%h y=%h with no point outstanding",
					got.x_out, got.y_out));
			return;
		end
		want = expected_warps.pop_front();
		warps_checked++;
		if (got.x_out !== want.x_out)
			report_mismatch($sformatf("warp %0d x_out: got %h want %h",
					warps_checked, got.x_out, want.x_out));
		if (got.y_out !== want.y_out)
			report_mismatch($sformatf("warp %0d y_out: got %h want %h",
					warps_checked, got.y_out, want.y_out));
	endtask

	// test sequence
	initial begin : sequencer
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);
		test_directed_points();
		test_register_extremes();
		test_random_settings();
		test_backpressure();
		settle();
		// catch any stray transfer after the last one
		repeat (LATENCY + 12) @(posedge clk);
		$display("%0d points sent, %0d warped points checked, %0d took the border push",
				points_sent, warps_checked, border_hits);
		$display("settings: reset, zero writes, full scale, both weight extremes; %0d input stalls",
				input_stalls);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// run limit
	initial begin : watchdog
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ cell_border_point_warp.f @@
design/cbpw_pkg.sv
design/cell_border_point_warp.sv
sim/tb.sv
